[rtl/core/brse_pkg.sv]
package brse_pkg;

  localparam int PIX_BITS = 8;
  localparam int GAP_BITS = 8;
  localparam int ADDR_BITS = 3;
  localparam int DATA_BITS = 32;

  localparam logic [PIX_BITS-1:0] SET_VALUE = 8'd255;

  // register byte addresses
  localparam logic [ADDR_BITS-1:0] ADDR_GAP_LIMIT = 3'd0;

  localparam logic [GAP_BITS-1:0] GAP_LIMIT_RESET = 8'd3;

  // what one queued record carries: a closed segment, a flush, or both
  typedef struct packed {
    logic has_a;    // closed segment in the A slot
    logic has_b;    // frame-end flush in the B slot
    logic b_empty;  // flush is the empty-frame marker
  } hdr_t;

endpackage

[rtl/core/brse_front.sv]
module brse_front #(
  parameter int COORD_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [brse_pkg::GAP_BITS-1:0]   gap_limit,
  input  logic                            accept,
  input  logic [brse_pkg::PIX_BITS-1:0]   pixel_value,
  input  logic [COORD_BITS-1:0]           col,
  input  logic [COORD_BITS-1:0]           row,
  input  logic                            frame_end,
  output logic                            rec_valid,
  output brse_pkg::hdr_t                  rec_hdr,
  output logic [COORD_BITS-1:0]           a_row,
  output logic [COORD_BITS-1:0]           a_start,
  output logic [COORD_BITS:0]             a_count,
  output logic [COORD_BITS-1:0]           b_row,
  output logic [COORD_BITS-1:0]           b_start,
  output logic [COORD_BITS:0]             b_count,
  output logic                            have_open_o
);

  localparam int DW = (COORD_BITS > brse_pkg::GAP_BITS) ? COORD_BITS : brse_pkg::GAP_BITS;
  localparam logic [COORD_BITS:0] CNT_MAX = {(COORD_BITS+1){1'b1}};

  logic                  have_open;
  logic [COORD_BITS-1:0] prev_col;
  logic [COORD_BITS-1:0] open_row;
  logic [COORD_BITS-1:0] open_start;
  logic [COORD_BITS:0]   open_count;

  logic                  have_open_next;
  logic [COORD_BITS-1:0] open_row_next;
  logic [COORD_BITS-1:0] open_start_next;
  logic [COORD_BITS:0]   open_count_next;

  logic                  is_set;
  logic [COORD_BITS-1:0] diff;
  logic                  join_seg;
  logic                  closing;

  always_comb begin
    is_set = (pixel_value == brse_pkg::SET_VALUE);
    diff = (col >= prev_col) ? (col - prev_col) : (prev_col - col);
    join_seg = have_open && (row == open_row) && (DW'(diff) <= DW'(gap_limit));
    closing = is_set && have_open && !join_seg;

    have_open_next = have_open | is_set;
    open_row_next = open_row;
    open_start_next = open_start;
    open_count_next = open_count;
    if (is_set) begin
      if (join_seg) begin
        if (open_count != CNT_MAX) begin
          open_count_next = open_count + 1'b1;
        end
      end else begin
        open_row_next = row;
        open_start_next = col;
        open_count_next = {{COORD_BITS{1'b0}}, 1'b1};
      end
    end
  end

  always_comb begin
    rec_hdr.has_a = closing;
    rec_hdr.has_b = frame_end;
    rec_hdr.b_empty = !have_open_next;
    rec_valid = accept && (closing || frame_end);
    a_row = open_row;
    a_start = open_start;
    a_count = open_count;
    b_row = have_open_next ? open_row_next : '0;
    b_start = have_open_next ? open_start_next : '0;
    b_count = have_open_next ? open_count_next : '0;
  end

  assign have_open_o = have_open;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_open <= 1'b0;
      prev_col <= '0;
      open_row <= '0;
      open_start <= '0;
      open_count <= '0;
    end else if (accept) begin
      if (frame_end) begin
        have_open <= 1'b0;
        prev_col <= '0;
        open_row <= '0;
        open_start <= '0;
        open_count <= '0;
      end else begin
        have_open <= have_open_next;
        open_row <= open_row_next;
        open_start <= open_start_next;
        open_count <= open_count_next;
        if (is_set) begin
          prev_col <= col;
        end
      end
    end
  end

endmodule

[rtl/core/brse_fifo.sv]
module brse_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;

  assign full = (count == FULL_CNT);
  assign empty = (count == '0);
  assign rd_data = entries[rptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wptr <= (wptr == LAST_PTR) ? '0 : wptr + 1'b1;
      end
      if (rd_en) begin
        rptr <= (rptr == LAST_PTR) ? '0 : rptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (!wr_en && rd_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/core/brse_back.sv]
module brse_back #(
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_empty,
  input  brse_pkg::hdr_t        q_hdr,
  input  logic [COORD_BITS-1:0] q_a_row,
  input  logic [COORD_BITS-1:0] q_a_start,
  input  logic [COORD_BITS:0]   q_a_count,
  input  logic [COORD_BITS-1:0] q_b_row,
  input  logic [COORD_BITS-1:0] q_b_start,
  input  logic [COORD_BITS:0]   q_b_count,
  output logic                  q_rd,
  input  logic                  pop,
  output logic                  empty,
  output logic [COORD_BITS-1:0] seg_row,
  output logic [COORD_BITS-1:0] seg_start,
  output logic [COORD_BITS:0]   seg_count,
  output logic                  frame_empty,
  output logic                  last
);

  // set once the A result of the head record has been transferred while its B result remains
  logic sub;
  logic show_a;
  logic take;

  always_comb begin
    show_a = q_hdr.has_a && !sub;
    take = pop && !q_empty;
    empty = q_empty;
    seg_row = show_a ? q_a_row : q_b_row;
    seg_start = show_a ? q_a_start : q_b_start;
    seg_count = show_a ? q_a_count : q_b_count;
    frame_empty = !show_a && q_hdr.b_empty;
    last = show_a ? !q_hdr.has_b : 1'b1;
    q_rd = take && !(show_a && q_hdr.has_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sub <= 1'b0;
    end else if (take) begin
      sub <= show_a && q_hdr.has_b;
    end
  end

endmodule

[rtl/core/binary_row_segment_extractor_core.sv]
// Channel   Handshake                 Payload
// input     push / full               pixel_value, col, row, frame_end
// result    empty / pop               seg_row, seg_start, seg_count, frame_empty, last
// config    psel/penable/pwrite/...   paddr, pwdata, prdata (gap_limit at 0x0)
//
// One pixel is taken per cycle while full is low; segment state updates in the
// cycle of the transfer. Records with results go to a QDEPTH-entry queue; the
// result side drains one result per cycle, so a pixel with a closed segment and a
// flush takes two pops. full rises only when the queue holds QDEPTH records;
// pixels with no result never enter the queue. rst is synchronous: segment state
// and queue cleared, gap_limit back to 3.
module binary_row_segment_extractor_core #(
  parameter int COORD_BITS = 12,
  parameter int QDEPTH = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic [brse_pkg::PIX_BITS-1:0]       pixel_value,
  input  logic [COORD_BITS-1:0]               col,
  input  logic [COORD_BITS-1:0]               row,
  input  logic                                frame_end,
  output logic                                empty,
  input  logic                                pop,
  output logic [COORD_BITS-1:0]               seg_row,
  output logic [COORD_BITS-1:0]               seg_start,
  output logic [COORD_BITS:0]                 seg_count,
  output logic                                frame_empty,
  output logic                                last,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [brse_pkg::ADDR_BITS-1:0]      paddr,
  input  logic [brse_pkg::DATA_BITS-1:0]      pwdata,
  output logic [brse_pkg::DATA_BITS-1:0]      prdata,
  output logic                                pready
);

  localparam int SEGW = 3 * COORD_BITS + 1;
  localparam int HW = $bits(brse_pkg::hdr_t);
  localparam int RECW = HW + 2 * SEGW;

  logic [brse_pkg::GAP_BITS-1:0] gap_limit;
  logic                          accept;
  logic                          rec_valid;
  brse_pkg::hdr_t                rec_hdr;
  logic [COORD_BITS-1:0]         a_row;
  logic [COORD_BITS-1:0]         a_start;
  logic [COORD_BITS:0]           a_count;
  logic [COORD_BITS-1:0]         b_row;
  logic [COORD_BITS-1:0]         b_start;
  logic [COORD_BITS:0]           b_count;
  logic                          have_open;
  logic [RECW-1:0]               wr_rec;
  logic [RECW-1:0]               rd_rec;
  logic                          q_rd;
  logic                          q_empty;
  brse_pkg::hdr_t                q_hdr;

  assign pready = 1'b1;
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_limit <= brse_pkg::GAP_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && paddr == brse_pkg::ADDR_GAP_LIMIT) begin
      gap_limit <= pwdata[brse_pkg::GAP_BITS-1:0];
    end
  end

  assign prdata = (paddr == brse_pkg::ADDR_GAP_LIMIT) ?
                  brse_pkg::DATA_BITS'(gap_limit) : '0;

  brse_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .gap_limit  (gap_limit),
    .accept     (accept),
    .pixel_value(pixel_value),
    .col        (col),
    .row        (row),
    .frame_end  (frame_end),
    .rec_valid  (rec_valid),
    .rec_hdr    (rec_hdr),
    .a_row      (a_row),
    .a_start    (a_start),
    .a_count    (a_count),
    .b_row      (b_row),
    .b_start    (b_start),
    .b_count    (b_count),
    .have_open_o(have_open)
  );

  assign wr_rec = {rec_hdr, a_row, a_start, a_count, b_row, b_start, b_count};

  brse_fifo #(.WIDTH(RECW), .DEPTH(QDEPTH)) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (rec_valid),
    .wr_data(wr_rec),
    .rd_en  (q_rd),
    .rd_data(rd_rec),
    .full   (full),
    .empty  (q_empty)
  );

  assign q_hdr = brse_pkg::hdr_t'(rd_rec[RECW-1 -: HW]);

  brse_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_hdr      (q_hdr),
    .q_a_row    (rd_rec[2*SEGW-1 -: COORD_BITS]),
    .q_a_start  (rd_rec[2*SEGW-COORD_BITS-1 -: COORD_BITS]),
    .q_a_count  (rd_rec[SEGW+COORD_BITS:SEGW]),
    .q_b_row    (rd_rec[SEGW-1 -: COORD_BITS]),
    .q_b_start  (rd_rec[SEGW-COORD_BITS-1 -: COORD_BITS]),
    .q_b_count  (rd_rec[COORD_BITS:0]),
    .q_rd       (q_rd),
    .pop        (pop),
    .empty      (empty),
    .seg_row    (seg_row),
    .seg_start  (seg_start),
    .seg_count  (seg_count),
    .frame_empty(frame_empty),
    .last       (last)
  );

`ifndef SYNTHESIS
  // the empty-frame marker is always alone and carries a zero count
  a_marker_alone: assert property (@(posedge clk) disable iff (rst)
    (!empty && frame_empty) |-> (last && seg_count == '0))
    else $error("empty marker not final or nonzero count");

  // a real segment always holds at least one set pixel
  a_seg_nonzero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !frame_empty) |-> (seg_count != '0))
    else $error("segment with zero count");

  // frame end leaves no segment open
  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && frame_end) |=> !have_open)
    else $error("segment still open after frame end");

  // a record is never written into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    rec_valid |-> (push && !full))
    else $error("record written without a pixel transfer");
`endif

endmodule
